FILE: rtl/midi_clocked_step_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the step sequencer core.
// ----------------------------------------------------------------------------
`ifndef MIDI_CLOCKED_STEP_SEQUENCER_CORE_MACROS_SVH
`define MIDI_CLOCKED_STEP_SEQUENCER_CORE_MACROS_SVH

// Concurrent check on an explicit clock and reset
`define MCSS_ASSERT_ON(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on the block clock and reset
`define MCSS_ASSERT(lbl, prop, msg) `MCSS_ASSERT_ON(lbl, clock, reset, prop, msg)

`endif

FILE: rtl/mcss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_pkg
// Types, codes and constants of the MIDI clocked step sequencer.
// ----------------------------------------------------------------------------
package mcss_pkg;

   // Default geometry and timing
   localparam int STAGES_DEF            = 8;
   localparam int TICKS_PER_STEP_DEF    = 6;
   localparam int TICKS_PER_QUARTER_DEF = 24;
   localparam int BEATS_PER_BAR_DEF     = 4;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Operations
   localparam logic [2:0] OP_START    = 3'd0;
   localparam logic [2:0] OP_STOP     = 3'd1;
   localparam logic [2:0] OP_CONTINUE = 3'd2;
   localparam logic [2:0] OP_CLOCK    = 3'd3;
   localparam logic [2:0] OP_EDIT     = 3'd4;

   // Edit markers
   localparam logic [3:0] MK_NOTE     = 4'd1;
   localparam logic [3:0] MK_SHARP    = 4'd2;
   localparam logic [3:0] MK_FLAT     = 4'd3;
   localparam logic [3:0] MK_OCT_UP   = 4'd4;
   localparam logic [3:0] MK_OCT_DOWN = 4'd5;
   localparam logic [3:0] MK_VEL_UP   = 4'd6;
   localparam logic [3:0] MK_VEL_DOWN = 4'd7;
   localparam logic [3:0] MK_EXTEND   = 4'd8;
   localparam logic [3:0] MK_REPEAT   = 4'd9;
   localparam logic [3:0] MK_TIE      = 4'd10;
   localparam logic [3:0] MK_LEGATO   = 4'd11;

   // Register indexes
   localparam logic [2:0] CSR_MIDI_CHANNEL  = 3'd0;
   localparam logic [2:0] CSR_RESET_MODE    = 3'd1;
   localparam logic [2:0] CSR_BASE_OCTAVE   = 3'd2;
   localparam logic [2:0] CSR_BASE_VELOCITY = 3'd3;
   localparam logic [2:0] CSR_VELOCITY_STEP = 3'd4;

   // Register reset values
   localparam logic [3:0] RST_MIDI_CHANNEL  = 4'd0;
   localparam logic [1:0] RST_RESET_MODE    = 2'd1;
   localparam logic [3:0] RST_BASE_OCTAVE   = 4'd4;
   localparam logic [6:0] RST_BASE_VELOCITY = 7'd100;
   localparam logic [6:0] RST_VELOCITY_STEP = 7'd16;

   // Position reset modes
   localparam logic [1:0] MODE_EVERY_BAR  = 2'd1;
   localparam logic [1:0] MODE_EVEN_BAR   = 2'd2;

   // Message kinds
   localparam logic KIND_OFF = 1'b0;
   localparam logic KIND_ON  = 1'b1;

   localparam logic [6:0] VEL_MAX = 7'd127;
   localparam logic [6:0] VEL_MIN = 7'd1;

   typedef struct packed {
      logic       present;
      logic [2:0] degree;
      logic [7:0] count;
      logic [7:0] accidental;
      logic [7:0] octave;
      logic [7:0] velocity;
   } pitch_type;

   typedef struct packed {
      logic [7:0] extend;
      logic [7:0] rpt;
      logic [7:0] tie;
      logic [7:0] legato;
   } timing_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [2:0] edit_row;
      logic [2:0] edit_column;
      logic [3:0] edit_marker;
      logic       edit_on;
   } item_type;

   typedef struct packed {
      logic       message_kind;
      logic [3:0] channel;
      logic [7:0] note_number;
      logic [6:0] velocity;
      logic       last;
   } msg_type;

   // Semitone offset of each scale degree
   function automatic logic [7:0] scale_step(input logic [2:0] degree);
      logic [7:0] s;
      case (degree)
         3'd0:    s = 8'd0;
         3'd1:    s = 8'd2;
         3'd2:    s = 8'd4;
         3'd3:    s = 8'd5;
         3'd4:    s = 8'd7;
         3'd5:    s = 8'd9;
         3'd6:    s = 8'd11;
         default: s = 8'd12;
      endcase
      return s;
   endfunction

   // Build one message
   function automatic msg_type make_msg(input logic kind, input logic [3:0] chan,
                                        input logic [7:0] note, input logic [6:0] vel,
                                        input logic last);
      msg_type m;
      m.message_kind = kind;
      m.channel      = chan;
      m.note_number  = note;
      m.velocity     = vel;
      m.last         = last;
      return m;
   endfunction

endpackage

FILE: rtl/mcss_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_req_if
// Request channel: transport events and stage edits.
// ----------------------------------------------------------------------------
interface mcss_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [2:0] edit_row;
   logic [2:0] edit_column;
   logic [3:0] edit_marker;
   logic       edit_on;

   modport source (output valid, operation, edit_row, edit_column, edit_marker, edit_on,
                   input ready);
   modport sink   (input valid, operation, edit_row, edit_column, edit_marker, edit_on,
                   output ready);
endinterface

FILE: rtl/mcss_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_rsp_if
// Response channel: note-on and note-off messages.
// ----------------------------------------------------------------------------
interface mcss_rsp_if;
   logic       valid;
   logic       ready;
   logic       message_kind;
   logic [3:0] channel;
   logic [7:0] note_number;
   logic [6:0] velocity;
   logic       last;

   modport source (output valid, message_kind, channel, note_number, velocity, last,
                   input ready);
   modport sink   (input valid, message_kind, channel, note_number, velocity, last,
                   output ready);
endinterface

FILE: rtl/mcss_stage_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_stage_table
// Per-stage pitch and timing counters, with the marker edit logic.
// ----------------------------------------------------------------------------
module mcss_stage_table #(
   parameter int STAGES = mcss_pkg::STAGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      edit_en,
   input  mcss_pkg::item_type        edit_item,
   input  logic [$clog2(STAGES)-1:0] rd_index,
   output mcss_pkg::pitch_type       rd_pitch,
   output mcss_pkg::timing_type      rd_timing
);

   localparam int SIDX_W = $clog2(STAGES);
   localparam int COL_W  = (SIDX_W > 3) ? SIDX_W : 3;

   mcss_pkg::pitch_type  pitch_ff  [STAGES];
   mcss_pkg::timing_type timing_ff [STAGES];
   mcss_pkg::pitch_type  pitch_in;
   mcss_pkg::timing_type timing_in;

   logic [COL_W-1:0]  col_wide;
   logic [SIDX_W-1:0] wr_index;
   logic              col_ok;
   logic [7:0]        inc;
   logic [7:0]        dec;
   logic              count_pos;

   assign col_wide = COL_W'(edit_item.edit_column);
   assign wr_index = col_wide[SIDX_W-1:0];
   assign col_ok   = (32'(edit_item.edit_column) < 32'(STAGES));
   assign inc      = edit_item.edit_on ? 8'h01 : 8'hFF;
   assign dec      = edit_item.edit_on ? 8'hFF : 8'h01;

   assign rd_pitch  = pitch_ff[rd_index];
   assign rd_timing = timing_ff[rd_index];

   // Apply one marker change to the addressed stage
   always_comb begin
      pitch_in  = pitch_ff[wr_index];
      timing_in = timing_ff[wr_index];
      count_pos = !pitch_in.count[7] && (pitch_in.count != 8'd0);
      unique case (edit_item.edit_marker)
         mcss_pkg::MK_NOTE: begin
            // an added note replaces the old one, so a positive count holds
            if (edit_item.edit_on) begin
               pitch_in.count  = count_pos ? pitch_in.count : pitch_in.count + 8'd1;
               pitch_in.degree = edit_item.edit_row;
            end else begin
               pitch_in.count  = pitch_in.count - 8'd1;
               pitch_in.degree = 3'd0;
            end
            pitch_in.present = edit_item.edit_on;
         end
         mcss_pkg::MK_SHARP:    pitch_in.accidental = pitch_in.accidental + inc;
         mcss_pkg::MK_FLAT:     pitch_in.accidental = pitch_in.accidental + dec;
         mcss_pkg::MK_OCT_UP:   pitch_in.octave     = pitch_in.octave + inc;
         mcss_pkg::MK_OCT_DOWN: pitch_in.octave     = pitch_in.octave + dec;
         mcss_pkg::MK_VEL_UP:   pitch_in.velocity   = pitch_in.velocity + inc;
         mcss_pkg::MK_VEL_DOWN: pitch_in.velocity   = pitch_in.velocity + dec;
         mcss_pkg::MK_EXTEND:   timing_in.extend    = timing_in.extend + inc;
         mcss_pkg::MK_REPEAT:   timing_in.rpt       = timing_in.rpt + inc;
         mcss_pkg::MK_TIE:      timing_in.tie       = timing_in.tie + inc;
         mcss_pkg::MK_LEGATO:   timing_in.legato    = timing_in.legato + inc;
         default: ;
      endcase
   end

   // Table registers, cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            pitch_ff[i]  <= '0;
            timing_ff[i] <= '0;
         end
      end else if (edit_en && col_ok) begin
         pitch_ff[wr_index]  <= pitch_in;
         timing_ff[wr_index] <= timing_in;
      end
   end

endmodule

FILE: rtl/mcss_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_out_queue
// Small result queue: takes up to two messages a cycle, sends one a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module mcss_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_cnt,
   input  mcss_pkg::msg_type msg_a,
   input  mcss_pkg::msg_type msg_b,
   output logic              room,
   mcss_rsp_if.source        rsp_if
);

   mcss_pkg::msg_type                 mem_ff [mcss_pkg::QUEUE_DEPTH];
   logic [mcss_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mcss_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mcss_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic [mcss_pkg::QPTR_W-1:0]       wr_ptr_b;
   logic                              pop;
   mcss_pkg::msg_type                 head;

   // Room for a full two-message burst
   assign room     = (count_ff <= mcss_pkg::QCNT_W'(mcss_pkg::QUEUE_DEPTH - 2));
   assign pop      = rsp_if.valid && rsp_if.ready;
   assign wr_ptr_b = wr_ptr_ff + mcss_pkg::QPTR_W'(1);
   assign head     = mem_ff[rd_ptr_ff];

   assign rsp_if.valid        = (count_ff != '0);
   assign rsp_if.message_kind = head.message_kind;
   assign rsp_if.channel      = head.channel;
   assign rsp_if.note_number  = head.note_number;
   assign rsp_if.velocity     = head.velocity;
   assign rsp_if.last         = head.last;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + mcss_pkg::QPTR_W'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + mcss_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + mcss_pkg::QCNT_W'(push_cnt)
                  - mcss_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= msg_a;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_b] <= msg_b;
      end
   end

endmodule

FILE: rtl/midi_clocked_step_sequencer_core.sv
`timescale 1ns / 1ps
// Path: a request is captured in the input register, then processed into the result
//   queue, from which its messages transfer on the response channel.
// Throughput: one request per cycle while the result queue has room for two messages;
//   messages leave one at a time, so the four-entry result queue paces requests that cause two messages.
// Reset: synchronous, active high; clears stage table and transport state, and loads the register reset values.
// ----------------------------------------------------------------------------
// midi_clocked_step_sequencer_core
// MIDI clocked step sequencer: transport, position counters and note messages.
// ----------------------------------------------------------------------------
`include "midi_clocked_step_sequencer_core_macros.svh"

module midi_clocked_step_sequencer_core #(
   parameter int STAGES            = mcss_pkg::STAGES_DEF,
   parameter int TICKS_PER_STEP    = mcss_pkg::TICKS_PER_STEP_DEF,
   parameter int TICKS_PER_QUARTER = mcss_pkg::TICKS_PER_QUARTER_DEF,
   parameter int BEATS_PER_BAR     = mcss_pkg::BEATS_PER_BAR_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mcss_req_if.sink   req_if,
   mcss_rsp_if.source rsp_if,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [6:0] csr_wdata
);

   localparam int SIDX_W  = $clog2(STAGES);
   localparam int TICK_W  = (TICKS_PER_QUARTER > 1) ? $clog2(TICKS_PER_QUARTER) : 1;
   localparam int PHASE_W = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;
   localparam int BEAT_W  = (BEATS_PER_BAR > 1) ? $clog2(BEATS_PER_BAR) : 1;

   // Configuration registers
   logic [3:0] cfg_channel_ff;
   logic [1:0] cfg_mode_ff;
   logic [3:0] cfg_octave_ff;
   logic [6:0] cfg_base_vel_ff;
   logic [6:0] cfg_vel_step_ff;

   // Input register
   mcss_pkg::item_type in_item_ff;
   logic               in_valid_ff, in_valid_in;
   logic               req_xfer;
   logic               proc_fire;

   // Sequencer state
   logic               running_ff, running_in;
   logic               sound_valid_ff, sound_valid_in;
   logic [7:0]         sound_note_ff, sound_note_in;
   logic [SIDX_W-1:0]  stage_ff, stage_in;
   logic [7:0]         rep_ff, rep_in;
   logic [7:0]         ext_ff, ext_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BEAT_W-1:0]  beat_ff, beat_in;
   logic               parity_ff, parity_in;

   // Processing signals
   logic                 room;
   logic [1:0]           push_cnt;
   mcss_pkg::msg_type    msg_a, msg_b;
   mcss_pkg::pitch_type  cur_pitch;
   mcss_pkg::timing_type cur_timing;
   logic [SIDX_W-1:0]    stage_eff;
   logic [7:0]           rep_eff, ext_eff, ext_inc, rep_inc;
   logic                 pos_reset;
   logic                 step_now;
   logic                 play, legato, note_on, off_first, off_after;
   logic                 tick_wrap, beat_wrap;
   logic [7:0]           oct_sum, note_calc;
   logic signed [15:0]   vel_prod;
   logic signed [16:0]   vel_sum;
   logic [6:0]           vel_calc;
   logic [7:0]           vel_sig;

   // Check terms
   logic                 stop_fire;
   logic                 stalled;
   logic                 silent;

   assign req_xfer     = req_if.valid && req_if.ready;
   assign proc_fire    = in_valid_ff && room;
   assign req_if.ready = !in_valid_ff || proc_fire;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_channel_ff  <= mcss_pkg::RST_MIDI_CHANNEL;
         cfg_mode_ff     <= mcss_pkg::RST_RESET_MODE;
         cfg_octave_ff   <= mcss_pkg::RST_BASE_OCTAVE;
         cfg_base_vel_ff <= mcss_pkg::RST_BASE_VELOCITY;
         cfg_vel_step_ff <= mcss_pkg::RST_VELOCITY_STEP;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mcss_pkg::CSR_MIDI_CHANNEL:  cfg_channel_ff  <= csr_wdata[3:0];
            mcss_pkg::CSR_RESET_MODE:    cfg_mode_ff     <= csr_wdata[1:0];
            mcss_pkg::CSR_BASE_OCTAVE:   cfg_octave_ff   <= csr_wdata[3:0];
            mcss_pkg::CSR_BASE_VELOCITY: cfg_base_vel_ff <= csr_wdata;
            mcss_pkg::CSR_VELOCITY_STEP: cfg_vel_step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register: hold the item until the queue has room
   assign in_valid_in = req_xfer || (in_valid_ff && !proc_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.operation   <= req_if.operation;
         in_item_ff.edit_row    <= req_if.edit_row;
         in_item_ff.edit_column <= req_if.edit_column;
         in_item_ff.edit_marker <= req_if.edit_marker;
         in_item_ff.edit_on     <= req_if.edit_on;
      end
   end

   // Stage table
   mcss_stage_table #(
      .STAGES (STAGES)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .edit_en   (proc_fire && (in_item_ff.operation == mcss_pkg::OP_EDIT)),
      .edit_item (in_item_ff),
      .rd_index  (stage_eff),
      .rd_pitch  (cur_pitch),
      .rd_timing (cur_timing)
   );

   // Position reset at the start of a measure: every bar or every even bar, by reset mode
   assign step_now  = running_ff && (in_item_ff.operation == mcss_pkg::OP_CLOCK)
                      && (phase_ff == '0);
   assign pos_reset = (beat_ff == '0) && (tick_ff == '0)
                      && ((cfg_mode_ff == mcss_pkg::MODE_EVERY_BAR)
                          || ((cfg_mode_ff == mcss_pkg::MODE_EVEN_BAR) && !parity_ff));
   assign stage_eff = pos_reset ? '0 : stage_ff;
   assign rep_eff   = pos_reset ? 8'd0 : rep_ff;
   assign ext_eff   = pos_reset ? 8'd0 : ext_ff;

   // Note number, modulo 256
   assign oct_sum   = {4'd0, cfg_octave_ff} + cur_pitch.octave;
   assign note_calc = {oct_sum[4:0], 3'd0} + {oct_sum[5:0], 2'd0}
                      + mcss_pkg::scale_step(cur_pitch.degree) + cur_pitch.accidental;

   // Velocity, computed wide and clamped to 1..127
   assign vel_sig  = {1'b0, cfg_vel_step_ff};
   assign vel_prod = $signed(cur_pitch.velocity) * $signed(vel_sig);
   assign vel_sum  = $signed({vel_prod[15], vel_prod}) + $signed({10'd0, cfg_base_vel_ff});

   always_comb begin
      if (vel_sum < 17'sd1) begin
         vel_calc = mcss_pkg::VEL_MIN;
      end else if (vel_sum > 17'sd127) begin
         vel_calc = mcss_pkg::VEL_MAX;
      end else begin
         vel_calc = vel_sum[6:0];
      end
   end

   // Decide which messages this step sends
   assign play      = (cur_timing.tie[7] || (cur_timing.tie == 8'd0)) && (ext_eff == 8'd0);
   assign legato    = !cur_timing.legato[7] && (cur_timing.legato != 8'd0);
   assign note_on   = play && cur_pitch.present
                      && !cur_pitch.count[7] && (cur_pitch.count != 8'd0);
   assign off_first = play && !legato && sound_valid_ff;
   assign off_after = play && legato && sound_valid_ff;

   assign ext_inc   = ext_eff + 8'd1;
   assign tick_wrap = (tick_ff == TICK_W'(TICKS_PER_QUARTER - 1));
   assign beat_wrap = (beat_ff == BEAT_W'(BEATS_PER_BAR - 1));

   // Process one item
   always_comb begin
      running_in     = running_ff;
      sound_valid_in = sound_valid_ff;
      sound_note_in  = sound_note_ff;
      stage_in       = stage_ff;
      rep_in         = rep_ff;
      ext_in         = ext_ff;
      tick_in        = tick_ff;
      phase_in       = phase_ff;
      beat_in        = beat_ff;
      parity_in      = parity_ff;
      rep_inc        = rep_eff;
      push_cnt       = 2'd0;
      msg_a = mcss_pkg::make_msg(mcss_pkg::KIND_OFF, cfg_channel_ff, sound_note_ff,
                                 7'd0, 1'b1);
      msg_b = msg_a;

      if (proc_fire) begin
         unique case (in_item_ff.operation)
            mcss_pkg::OP_START: begin
               running_in = 1'b1;
               tick_in    = '0;
               phase_in   = '0;
               beat_in    = '0;
               parity_in  = 1'b0;
               stage_in   = '0;
            end
            mcss_pkg::OP_STOP: begin
               running_in = 1'b0;
               if (sound_valid_ff) begin
                  push_cnt       = 2'd1;
                  sound_valid_in = 1'b0;
               end
            end
            mcss_pkg::OP_CONTINUE: begin
               running_in = 1'b1;
            end
            mcss_pkg::OP_CLOCK: begin
               if (running_ff) begin
                  if (step_now) begin
                     // messages: off before on, or on before off for legato
                     if (off_first) begin
                        sound_valid_in = 1'b0;
                        if (note_on) begin
                           msg_a.last = 1'b0;
                           msg_b = mcss_pkg::make_msg(mcss_pkg::KIND_ON, cfg_channel_ff,
                                                      note_calc, vel_calc, 1'b1);
                           push_cnt = 2'd2;
                        end else begin
                           push_cnt = 2'd1;
                        end
                     end else if (note_on) begin
                        msg_a = mcss_pkg::make_msg(mcss_pkg::KIND_ON, cfg_channel_ff,
                                                   note_calc, vel_calc, !off_after);
                        push_cnt = off_after ? 2'd2 : 2'd1;
                     end else if (off_after) begin
                        push_cnt = 2'd1;
                     end
                     if (note_on) begin
                        sound_valid_in = 1'b1;
                        sound_note_in  = note_calc;
                     end

                     // advance extension, repeat and stage positions
                     ext_in = ext_inc;
                     if ($signed({1'b0, ext_inc}) >
                         $signed({cur_timing.extend[7], cur_timing.extend})) begin
                        ext_in  = 8'd0;
                        rep_inc = rep_eff + 8'd1;
                     end
                     rep_in   = rep_inc;
                     stage_in = stage_eff;
                     if ($signed({1'b0, rep_inc}) >
                         $signed({cur_timing.rpt[7], cur_timing.rpt})) begin
                        rep_in   = 8'd0;
                        stage_in = (stage_eff == SIDX_W'(STAGES - 1)) ?
                                   '0 : stage_eff + SIDX_W'(1);
                     end
                  end

                  // tick, beat and measure counters
                  if (tick_wrap) begin
                     tick_in  = '0;
                     phase_in = '0;
                     beat_in  = beat_wrap ? '0 : beat_ff + BEAT_W'(1);
                     if (beat_wrap) begin
                        parity_in = !parity_ff;
                     end
                  end else begin
                     tick_in  = tick_ff + TICK_W'(1);
                     phase_in = (phase_ff == PHASE_W'(TICKS_PER_STEP - 1)) ?
                                '0 : phase_ff + PHASE_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Sequencer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         sound_valid_ff <= 1'b0;
         sound_note_ff  <= 8'd0;
         stage_ff       <= '0;
         rep_ff         <= 8'd0;
         ext_ff         <= 8'd0;
         tick_ff        <= '0;
         phase_ff       <= '0;
         beat_ff        <= '0;
         parity_ff      <= 1'b0;
      end else begin
         running_ff     <= running_in;
         sound_valid_ff <= sound_valid_in;
         sound_note_ff  <= sound_note_in;
         stage_ff       <= stage_in;
         rep_ff         <= rep_in;
         ext_ff         <= ext_in;
         tick_ff        <= tick_in;
         phase_ff       <= phase_in;
         beat_ff        <= beat_in;
         parity_ff      <= parity_in;
      end
   end

   // Result queue
   mcss_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (push_cnt),
      .msg_a    (msg_a),
      .msg_b    (msg_b),
      .room     (room),
      .rsp_if   (rsp_if)
   );

   // Terms used by the checks
   assign stop_fire = proc_fire && (in_item_ff.operation == mcss_pkg::OP_STOP);
   assign stalled   = in_valid_ff && !proc_fire;
   assign silent    = !sound_valid_ff && !running_ff;

   // Checks
   `MCSS_ASSERT(a_push_only_on_fire, (push_cnt != 2'd0) |-> proc_fire, "push without room")
   `MCSS_ASSERT(a_pair_last, (push_cnt == 2'd2) |-> (msg_b.last && !msg_a.last), "bad last flag")
   `MCSS_ASSERT(a_stop_silences, stop_fire |=> silent, "stop left note sounding")
   `MCSS_ASSERT(a_stall_holds, stalled |=> in_valid_ff && $stable(in_item_ff), "stalled item lost")
   `MCSS_ASSERT(a_stage_range, 32'(stage_ff) < 32'(STAGES), "stage position out of range")

endmodule
